// ===== sv/keyboard_scancode_decoder_top_assert.svh =====
// Assertion macros for the scancode decoder checker.
// Relies on clk and rst being visible where a macro is used.
`ifndef KEYBOARD_SCANCODE_DECODER_TOP_ASSERT_SVH
`define KEYBOARD_SCANCODE_DECODER_TOP_ASSERT_SVH

// same-cycle implication, off during reset
`define KSD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ksd checker: property violated");

// next-cycle implication, off during reset
`define KSD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ksd checker: property violated");

// same-cycle implication, also checked around reset
`define KSD_ASSERT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |-> (cons)) \
    else $error("ksd checker: property violated");

`endif

// ===== sv/ksd_pkg.sv =====
// Shared constants, types and key tables for the scancode decoder.
// No dependencies.
`default_nettype none

package ksd_pkg;

  localparam int CMD_QUEUE_DEPTH_DEF = 32;

  // input kind / output target codes
  localparam logic KIND_SCAN  = 1'b0;
  localparam logic KIND_START = 1'b1;
  localparam logic TGT_HOST   = 1'b0;
  localparam logic TGT_KBD    = 1'b1;

  // keyboard protocol bytes
  localparam logic [7:0] LED_CMD     = 8'hED;
  localparam logic [7:0] ACK_BYTE    = 8'hFA;
  localparam logic [7:0] RESEND_BYTE = 8'hFE;

  // scancodes with special handling
  localparam logic [7:0] SC_BKSP       = 8'h0E;
  localparam logic [7:0] SC_ENTER      = 8'h1C;
  localparam logic [7:0] SC_LSHIFT     = 8'h2A;
  localparam logic [7:0] SC_RSHIFT     = 8'h36;
  localparam logic [7:0] SC_LSHIFT_REL = 8'hAA;
  localparam logic [7:0] SC_RSHIFT_REL = 8'hB6;
  localparam logic [7:0] SC_CAPS       = 8'h3A;
  localparam logic [7:0] SC_NUM        = 8'h45;
  localparam logic [7:0] SC_SCROLL     = 8'h46;

  // character codes
  localparam logic [7:0] CHR_BS      = 8'h08;
  localparam logic [7:0] CHR_LF      = 8'h0A;
  localparam logic [7:0] CHR_UPPER_A = 8'h41;
  localparam logic [7:0] CHR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CASE_OFFSET = 8'h20;

  // LED bit masks
  localparam logic [2:0] LED_CAPS   = 3'b100;
  localparam logic [2:0] LED_NUM    = 3'b010;
  localparam logic [2:0] LED_SCROLL = 3'b001;

  typedef struct packed {
    logic       target;
    logic [7:0] value;
    logic [2:0] leds;
    logic       last;
  } result_t;

  typedef struct packed {
    logic       char_valid;
    logic [7:0] char_code;
    logic [1:0] shift_next;
    logic [2:0] leds_next;
    logic       push_leds;
    logic       ack;
    logic       resend;
  } decode_t;

  // Japanese layout, plain and shifted tables folded into one lookup
  function automatic logic [7:0] key_char(input logic [6:0] idx, input logic shifted);
    logic [7:0] c;
    c = 8'h00;
    case (idx)
      7'h02: c = shifted ? 8'h21 : 8'h31;
      7'h03: c = shifted ? 8'h22 : 8'h32;
      7'h04: c = shifted ? 8'h23 : 8'h33;
      7'h05: c = shifted ? 8'h24 : 8'h34;
      7'h06: c = shifted ? 8'h25 : 8'h35;
      7'h07: c = shifted ? 8'h26 : 8'h36;
      7'h08: c = shifted ? 8'h27 : 8'h37;
      7'h09: c = shifted ? 8'h28 : 8'h38;
      7'h0A: c = shifted ? 8'h29 : 8'h39;
      7'h0B: c = shifted ? 8'h7E : 8'h30;
      7'h0C: c = 8'h2D;
      7'h0D: c = 8'h5E;
      7'h10: c = 8'h51;
      7'h11: c = 8'h57;
      7'h12: c = 8'h45;
      7'h13: c = 8'h52;
      7'h14: c = 8'h54;
      7'h15: c = 8'h59;
      7'h16: c = 8'h55;
      7'h17: c = 8'h49;
      7'h18: c = 8'h4F;
      7'h19: c = 8'h50;
      7'h1A: c = shifted ? 8'h60 : 8'h40;
      7'h1B: c = shifted ? 8'h7B : 8'h5B;
      7'h1E: c = 8'h41;
      7'h1F: c = 8'h53;
      7'h20: c = 8'h44;
      7'h21: c = 8'h46;
      7'h22: c = 8'h47;
      7'h23: c = 8'h48;
      7'h24: c = 8'h4A;
      7'h25: c = 8'h4B;
      7'h26: c = 8'h4C;
      7'h27: c = shifted ? 8'h2B : 8'h3B;
      7'h28: c = shifted ? 8'h2A : 8'h3A;
      7'h2B: c = shifted ? 8'h7D : 8'h5D;
      7'h2C: c = 8'h5A;
      7'h2D: c = 8'h58;
      7'h2E: c = 8'h43;
      7'h2F: c = 8'h56;
      7'h30: c = 8'h42;
      7'h31: c = 8'h4E;
      7'h32: c = 8'h4D;
      7'h33: c = shifted ? 8'h3C : 8'h2C;
      7'h34: c = shifted ? 8'h3E : 8'h2E;
      7'h35: c = shifted ? 8'h3F : 8'h2F;
      7'h37: c = 8'h2A;
      7'h39: c = 8'h20;
      7'h47: c = 8'h37;
      7'h48: c = 8'h38;
      7'h49: c = 8'h39;
      7'h4A: c = 8'h2D;
      7'h4B: c = 8'h34;
      7'h4C: c = 8'h35;
      7'h4D: c = 8'h36;
      7'h4E: c = 8'h2B;
      7'h4F: c = 8'h31;
      7'h50: c = 8'h32;
      7'h51: c = 8'h33;
      7'h52: c = 8'h30;
      7'h53: c = 8'h2E;
      7'h73: c = shifted ? 8'h5F : 8'h5C;
      7'h7D: c = shifted ? 8'h7C : 8'h5C;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== sv/ksd_decode.sv =====
// Per-beat decode: table lookup, case fixup, shift/lock/ack tracking.
// Depends on ksd_pkg.
`default_nettype none

module ksd_decode import ksd_pkg::*; (
  input  logic       kind,
  input  logic [7:0] scan_byte,
  input  logic [2:0] initial_leds,
  input  logic [1:0] shift_held,
  input  logic [2:0] lock_leds,
  input  logic       awaiting_ack,
  output decode_t    dec
);

  always_comb begin
    logic [7:0] ch;
    logic       caps;
    logic       sh;
    dec            = '0;
    dec.shift_next = shift_held;
    dec.leds_next  = lock_leds;
    ch             = 8'h00;
    caps           = lock_leds[2];
    sh             = |shift_held;
    if (kind == KIND_START) begin
      dec.leds_next = initial_leds;
      dec.push_leds = 1'b1;
    end else begin
      if (!scan_byte[7]) begin
        ch = key_char(scan_byte[6:0], sh);
        // letters go lower case unless exactly one of caps/shift is on
        if ((ch inside {[CHR_UPPER_A:CHR_UPPER_Z]}) && (caps == sh)) begin
          ch = ch + CASE_OFFSET;
        end
      end
      if (scan_byte == SC_BKSP) ch = CHR_BS;
      if (scan_byte == SC_ENTER) ch = CHR_LF;
      dec.char_valid = (ch != 8'h00);
      dec.char_code  = ch;
      case (scan_byte)
        SC_LSHIFT:     dec.shift_next[0] = 1'b1;
        SC_RSHIFT:     dec.shift_next[1] = 1'b1;
        SC_LSHIFT_REL: dec.shift_next[0] = 1'b0;
        SC_RSHIFT_REL: dec.shift_next[1] = 1'b0;
        SC_CAPS: begin
          dec.leds_next = lock_leds ^ LED_CAPS;
          dec.push_leds = 1'b1;
        end
        SC_NUM: begin
          dec.leds_next = lock_leds ^ LED_NUM;
          dec.push_leds = 1'b1;
        end
        SC_SCROLL: begin
          dec.leds_next = lock_leds ^ LED_SCROLL;
          dec.push_leds = 1'b1;
        end
        ACK_BYTE:    dec.ack    = 1'b1;
        RESEND_BYTE: dec.resend = awaiting_ack;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== sv/ksd_cmd_queue.sv =====
// Command byte queue: two banked memories (even/odd slots) so the LED
// command and LED byte land in the same cycle; front entry prefetched.
// Depends on ksd_pkg.
`default_nettype none

module ksd_cmd_queue import ksd_pkg::*; #(
  parameter int DEPTH = CMD_QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push_en,
  input  logic [2:0] push_leds,
  input  logic       pop_en,
  output logic       will_hold,
  output logic [7:0] front_byte
);

  localparam int PTR_W      = ($clog2(DEPTH) < 2) ? 2 : $clog2(DEPTH);
  localparam int CNT_W      = PTR_W + 1;
  localparam int BANK_W     = PTR_W - 1;
  localparam int BANK_DEPTH = 2 ** BANK_W;
  localparam logic [CNT_W-1:0] CAP    = CNT_W'(DEPTH);
  localparam logic [CNT_W-1:0] CAP_M1 = CNT_W'(DEPTH - 1);

  logic [PTR_W-1:0]  head;
  logic [PTR_W-1:0]  head_next;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;
  logic [PTR_W-1:0]  tail;
  logic [PTR_W-1:0]  tail1;
  logic              fit0;
  logic              fit1;
  logic [1:0]        n_push;
  logic [7:0]        led_byte;
  logic [BANK_W-1:0] ra;

  logic              we0, we1;
  logic [BANK_W-1:0] wa0, wa1;
  logic [7:0]        wd0, wd1;
  logic [7:0]        mem0 [BANK_DEPTH];
  logic [7:0]        mem1 [BANK_DEPTH];
  logic [7:0]        rd0, rd1;

  always_comb begin
    led_byte   = {5'b00000, push_leds};
    fit0       = push_en && (count < CAP);
    fit1       = push_en && (count < CAP_M1);
    n_push     = {1'b0, fit0} + {1'b0, fit1};
    tail       = head + count[PTR_W-1:0];
    tail1      = tail + PTR_W'(1);
    head_next  = head + PTR_W'(pop_en);
    count_next = count + CNT_W'(n_push) - CNT_W'(pop_en);
    ra         = head_next[PTR_W-1:1];
    // LED command goes to the tail slot, LED byte right after it
    if (!tail[0]) begin
      we0 = fit0; wa0 = tail[PTR_W-1:1];  wd0 = LED_CMD;
      we1 = fit1; wa1 = tail1[PTR_W-1:1]; wd1 = led_byte;
    end else begin
      we1 = fit0; wa1 = tail[PTR_W-1:1];  wd1 = LED_CMD;
      we0 = fit1; wa0 = tail1[PTR_W-1:1]; wd0 = led_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else begin
      head  <= head_next;
      count <= count_next;
    end
  end

  // registered reads with write-first bypass
  always_ff @(posedge clk) begin
    if (we0) mem0[wa0] <= wd0;
    if (we0 && (wa0 == ra)) rd0 <= wd0;
    else rd0 <= mem0[ra];
  end

  always_ff @(posedge clk) begin
    if (we1) mem1[wa1] <= wd1;
    if (we1 && (wa1 == ra)) rd1 <= wd1;
    else rd1 <= mem1[ra];
  end

  // empty queue: the byte popped is the LED command pushed this beat
  assign will_hold  = (count != '0) || push_en;
  assign front_byte = (count == '0) ? LED_CMD : (head[0] ? rd1 : rd0);

endmodule

`default_nettype wire

// ===== sv/keyboard_scancode_decoder_top.sv =====
// Scancode decoder top: input register, decode, command queue, result buffer.
// An input beat is held in the input register, its results in the result buffer.
// Throughput: one input beat per cycle while the result stream is not stalled; an item
// with two results takes two output beats and holds off the next step until the first has left.
// Reset (rst, synchronous): clears handshake, shift, LEDs, queue pointers, ack flag.
// Depends on ksd_pkg, ksd_decode, ksd_cmd_queue.
`default_nettype none

module keyboard_scancode_decoder_top import ksd_pkg::*; #(
  parameter int CMD_QUEUE_DEPTH = CMD_QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // configuration: initial LED bits
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_wr_data,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] scan_byte
  input  logic        s_axis_tuser,   // [0] kind
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] byte_value, [10:8] led_bits, [15:11] zero
  output logic        m_axis_tuser,   // [0] target
  output logic        m_axis_tlast    // last result of the input beat
);

  // input register
  logic       in_valid;
  logic       in_kind;
  logic [7:0] in_scan;

  // decoder state
  logic [2:0] initial_leds;
  logic [1:0] shift_held;
  logic [2:0] lock_leds;
  logic       awaiting_ack;
  logic [7:0] sent_byte;

  // result buffer: res0 is on the bus, res1 waits behind it
  result_t    res0;
  result_t    res1;
  logic [1:0] res_cnt;

  decode_t    dec;
  logic       advance;
  logic       awaiting_mid;
  logic       q_push;
  logic       q_pop;
  logic       q_will_hold;
  logic [7:0] q_front;
  logic       pop_want;
  result_t    new0;
  result_t    new1;
  logic [1:0] n_new;

  // Step fires when the buffer is empty or its last result leaves this cycle.
  assign advance       = in_valid && ((res_cnt == 2'd0) ||
                                      ((res_cnt == 2'd1) && m_axis_tready));
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_kind <= s_axis_tuser;
      in_scan <= s_axis_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      initial_leds <= 3'b000;
    end else if (cfg_wr_en) begin
      initial_leds <= cfg_wr_data;
    end
  end

  ksd_decode u_decode (
    .kind         (in_kind),
    .scan_byte    (in_scan),
    .initial_leds (initial_leds),
    .shift_held   (shift_held),
    .lock_leds    (lock_leds),
    .awaiting_ack (awaiting_ack),
    .dec          (dec)
  );

  // An ack clears the pending byte before the send check of the same beat.
  assign awaiting_mid = dec.ack ? 1'b0 : awaiting_ack;
  assign q_push       = advance && dec.push_leds;
  assign pop_want     = q_will_hold && !awaiting_mid;
  assign q_pop        = advance && pop_want;

  ksd_cmd_queue #(
    .DEPTH (CMD_QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_en    (q_push),
    .push_leds  (dec.leds_next),
    .pop_en     (q_pop),
    .will_hold  (q_will_hold),
    .front_byte (q_front)
  );

  // Gather results in order: character, resend, fresh command byte.
  always_comb begin
    new0  = '0;
    new1  = '0;
    n_new = 2'd0;
    if (dec.char_valid) begin
      new0.target = TGT_HOST;
      new0.value  = dec.char_code;
      n_new       = 2'd1;
    end
    if (dec.resend) begin
      if (n_new == 2'd0) begin
        new0.target = TGT_KBD;
        new0.value  = sent_byte;
        n_new       = 2'd1;
      end else if (n_new == 2'd1) begin
        new1.target = TGT_KBD;
        new1.value  = sent_byte;
        n_new       = 2'd2;
      end
    end
    if (pop_want) begin
      if (n_new == 2'd0) begin
        new0.target = TGT_KBD;
        new0.value  = q_front;
        n_new       = 2'd1;
      end else if (n_new == 2'd1) begin
        new1.target = TGT_KBD;
        new1.value  = q_front;
        n_new       = 2'd2;
      end
    end
    new0.leds = dec.leds_next;
    new1.leds = dec.leds_next;
    new0.last = (n_new == 2'd1);
    new1.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_held   <= 2'b00;
      lock_leds    <= 3'b000;
      awaiting_ack <= 1'b0;
    end else if (advance) begin
      shift_held   <= dec.shift_next;
      lock_leds    <= dec.leds_next;
      awaiting_ack <= q_pop ? 1'b1 : awaiting_mid;
    end
  end

  // byte kept for a resend request
  always_ff @(posedge clk) begin
    if (q_pop) begin
      sent_byte <= q_front;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_cnt <= 2'd0;
    end else if (advance) begin
      res_cnt <= n_new;
    end else if (m_axis_tvalid && m_axis_tready) begin
      res_cnt <= res_cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res0 <= new0;
      res1 <= new1;
    end else if (m_axis_tvalid && m_axis_tready) begin
      res0 <= res1;
    end
  end

  assign m_axis_tvalid = (res_cnt != 2'd0);
  assign m_axis_tdata  = {5'b00000, res0.leds, res0.value};
  assign m_axis_tuser  = res0.target;
  assign m_axis_tlast  = res0.last;

endmodule

`default_nettype wire

// ===== sv/ksd_checker.sv =====
// Port-level checker for the scancode decoder top, bound in below.
// Depends on keyboard_scancode_decoder_top_assert.svh.
`default_nettype none

`include "keyboard_scancode_decoder_top_assert.svh"

module ksd_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic        m_axis_tuser,
  input logic        m_axis_tlast
);

  // stalled result beat holds
  `KSD_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))

  // buffer empty right after reset
  `KSD_ASSERT_RST(a_reset_idle, $fell(rst), !m_axis_tvalid)

  // a character beat never carries a null code
  `KSD_ASSERT_IMP(a_char_nonzero, m_axis_tvalid && !m_axis_tuser, m_axis_tdata[7:0] != 8'h00)

  // pad bits above the LED field stay clear
  `KSD_ASSERT_IMP(a_pad_zero, m_axis_tvalid, m_axis_tdata[15:11] == 5'b00000)

endmodule

bind keyboard_scancode_decoder_top ksd_checker u_ksd_checker (.*);

`default_nettype wire

// ===== bench/tb.sv =====
// Self-checking bench for keyboard_scancode_decoder_top: directed table, then random
// keystroke, lock-key and keyboard-protocol sequences, checked beat by beat.
// Depends on ksd_pkg and the RTL under sv/.
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ksd_pkg::*;

  localparam int CMD_DEPTH     = CMD_QUEUE_DEPTH_DEF;
  localparam int RANDOM_ITEMS  = 1400;
  localparam int PHASES        = 6;
  localparam int DRAIN_CYCLES  = 8;       // drain margin after the last owed beat
  localparam int HOLD_CYCLES   = 300;     // long receiver hold-off
  localparam int LIMIT_CYCLES  = 300000;
  localparam int MAX_REPORTS   = 100;
  localparam int NUM_ROWS      = 25;

  localparam logic TYPED = 1'b1;
  localparam logic PRED  = 1'b0;

  // clock, reset and DUT pins; every input starts at a known value
  logic        clk;
  logic        rst           = 1'b1;
  logic        cfg_wr_en     = 1'b0;
  logic [2:0]  cfg_wr_data   = 3'd0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'h00;   // [7:0] scan_byte
  logic        s_axis_tuser  = 1'b0;    // [0] kind
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;            // [7:0] byte_value, [10:8] led_bits, [15:11] zero
  logic        m_axis_tuser;            // [0] target
  logic        m_axis_tlast;

  keyboard_scancode_decoder_top u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // ---------------------------------------------------------------------------
  // Key tables, Japanese layout, set 1 make codes 0x00..0x7F
  // ---------------------------------------------------------------------------
  logic [7:0] plain_keys [128] = '{
    'h00, 'h00, 'h31, 'h32, 'h33, 'h34, 'h35, 'h36,
    'h37, 'h38, 'h39, 'h30, 'h2D, 'h5E, 'h00, 'h00,
    'h51, 'h57, 'h45, 'h52, 'h54, 'h59, 'h55, 'h49,
    'h4F, 'h50, 'h40, 'h5B, 'h00, 'h00, 'h41, 'h53,
    'h44, 'h46, 'h47, 'h48, 'h4A, 'h4B, 'h4C, 'h3B,
    'h3A, 'h00, 'h00, 'h5D, 'h5A, 'h58, 'h43, 'h56,
    'h42, 'h4E, 'h4D, 'h2C, 'h2E, 'h2F, 'h00, 'h2A,
    'h00, 'h20, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00,
    'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 'h37,
    'h38, 'h39, 'h2D, 'h34, 'h35, 'h36, 'h2B, 'h31,
    'h32, 'h33, 'h30, 'h2E, 'h00, 'h00, 'h00, 'h00,
    'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00,
    'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00,
    'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00,
    'h00, 'h00, 'h00, 'h5C, 'h00, 'h00, 'h00, 'h00,
    'h00, 'h00, 'h00, 'h00, 'h00, 'h5C, 'h00, 'h00
  };

  logic [7:0] shifted_keys [128] = '{
    'h00, 'h00, 'h21, 'h22, 'h23, 'h24, 'h25, 'h26,
    'h27, 'h28, 'h29, 'h7E, 'h2D, 'h5E, 'h00, 'h00,
    'h51, 'h57, 'h45, 'h52, 'h54, 'h59, 'h55, 'h49,
    'h4F, 'h50, 'h60, 'h7B, 'h00, 'h00, 'h41, 'h53,
    'h44, 'h46, 'h47, 'h48, 'h4A, 'h4B, 'h4C, 'h2B,
    'h2A, 'h00, 'h00, 'h7D, 'h5A, 'h58, 'h43, 'h56,
    'h42, 'h4E, 'h4D, 'h3C, 'h3E, 'h3F, 'h00, 'h2A,
    'h00, 'h20, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00,
    'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 'h37,
    'h38, 'h39, 'h2D, 'h34, 'h35, 'h36, 'h2B, 'h31,
    'h32, 'h33, 'h30, 'h2E, 'h00, 'h00, 'h00, 'h00,
    'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00,
    'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00,
    'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00,
    'h00, 'h00, 'h00, 'h5F, 'h00, 'h00, 'h00, 'h00,
    'h00, 'h00, 'h00, 'h00, 'h00, 'h7C, 'h00, 'h00
  };

  // ---------------------------------------------------------------------------
  // Directed table. Rows marked TYPED carry their result by hand (at most one
  // beat); PRED rows go through the decoder model like the random part.
  // ---------------------------------------------------------------------------
  typedef struct packed {
    logic       kind;
    logic [7:0] scan;
    logic       typed;
    logic       has_res;
    logic       tgt;
    logic [7:0] val;
    logic [2:0] leds;
  } step_row_t;

  step_row_t directed_rows [NUM_ROWS] = '{
    '{KIND_SCAN,  8'h00,         TYPED, 1'b0, TGT_HOST, 8'h00,    3'd0}, // key with no char
    '{KIND_SCAN,  SC_BKSP,       TYPED, 1'b1, TGT_HOST, CHR_BS,   3'd0},
    '{KIND_SCAN,  SC_ENTER,      TYPED, 1'b1, TGT_HOST, CHR_LF,   3'd0},
    '{KIND_SCAN,  8'h1E,         TYPED, 1'b1, TGT_HOST, 8'h61,    3'd0}, // 'a', no caps/shift
    '{KIND_SCAN,  8'h7F,         TYPED, 1'b0, TGT_HOST, 8'h00,    3'd0}, // top of table
    '{KIND_SCAN,  8'h80,         TYPED, 1'b0, TGT_HOST, 8'h00,    3'd0}, // release code
    '{KIND_SCAN,  8'hFF,         TYPED, 1'b0, TGT_HOST, 8'h00,    3'd0},
    '{KIND_SCAN,  ACK_BYTE,      TYPED, 1'b0, TGT_HOST, 8'h00,    3'd0}, // ack, nothing sent
    '{KIND_SCAN,  RESEND_BYTE,   TYPED, 1'b0, TGT_HOST, 8'h00,    3'd0}, // resend, nothing sent
    '{KIND_SCAN,  SC_LSHIFT,     PRED,  1'b0, TGT_HOST, 8'h00,    3'd0},
    '{KIND_SCAN,  8'h02,         PRED,  1'b0, TGT_HOST, 8'h00,    3'd0},
    '{KIND_SCAN,  8'h1E,         PRED,  1'b0, TGT_HOST, 8'h00,    3'd0},
    '{KIND_SCAN,  SC_RSHIFT,     PRED,  1'b0, TGT_HOST, 8'h00,    3'd0},
    '{KIND_SCAN,  SC_LSHIFT_REL, PRED,  1'b0, TGT_HOST, 8'h00,    3'd0},
    '{KIND_SCAN,  8'h7D,         PRED,  1'b0, TGT_HOST, 8'h00,    3'd0}, // right shift only
    '{KIND_SCAN,  SC_RSHIFT_REL, PRED,  1'b0, TGT_HOST, 8'h00,    3'd0},
    '{KIND_SCAN,  8'h73,         PRED,  1'b0, TGT_HOST, 8'h00,    3'd0},
    '{KIND_SCAN,  SC_CAPS,       TYPED, 1'b1, TGT_KBD,  LED_CMD,  LED_CAPS},
    '{KIND_SCAN,  8'h1E,         PRED,  1'b0, TGT_HOST, 8'h00,    3'd0}, // caps on
    '{KIND_SCAN,  RESEND_BYTE,   PRED,  1'b0, TGT_HOST, 8'h00,    3'd0}, // resend pending cmd
    '{KIND_SCAN,  ACK_BYTE,      PRED,  1'b0, TGT_HOST, 8'h00,    3'd0}, // LED byte follows
    '{KIND_SCAN,  ACK_BYTE,      PRED,  1'b0, TGT_HOST, 8'h00,    3'd0},
    '{KIND_SCAN,  SC_NUM,        PRED,  1'b0, TGT_HOST, 8'h00,    3'd0},
    '{KIND_SCAN,  SC_SCROLL,     PRED,  1'b0, TGT_HOST, 8'h00,    3'd0}, // queued behind num
    '{KIND_START, 8'hFF,         PRED,  1'b0, TGT_HOST, 8'h00,    3'd0}  // load all LEDs
  };

  // ---------------------------------------------------------------------------
  // Decoder model state and the beats it still owes
  // ---------------------------------------------------------------------------
  logic [1:0] shift_keys   = 2'b00;     // bit0 left, bit1 right
  logic [2:0] led_state    = 3'd0;
  logic [2:0] start_leds   = 3'd0;
  logic [7:0] led_cmd_fifo [$];
  logic       ack_pending  = 1'b0;
  logic [7:0] sent_cmd     = 8'h00;
  result_t    expected_beats [$];

  bit         typed_active = 1'b0;
  step_row_t  typed_row;

  int         errors       = 0;
  int         beats_sent   = 0;
  int         burst_left   = 0;
  bit         gaps_on      = 1'b1;
  bit         hold_req     = 1'b0;
  int         cycle_count  = 0;

  // push 0xED and the LED byte, dropping what does not fit
  task automatic queue_led_cmd();
    if (led_cmd_fifo.size() < CMD_DEPTH) led_cmd_fifo.push_back(LED_CMD);
    if (led_cmd_fifo.size() < CMD_DEPTH) led_cmd_fifo.push_back({5'd0, led_state});
  endtask

  // one accepted input beat: update the model, queue the beats it causes
  task automatic decode_scancode(input logic kind, input logic [7:0] code);
    logic [7:0] ch;
    logic       tgts [2];
    logic [7:0] vals [2];
    int         n;
    result_t    r;
    n  = 0;
    ch = 8'h00;
    if (kind == KIND_START) begin
      led_state = start_leds;
      queue_led_cmd();
    end else begin
      if (!code[7]) begin
        ch = (shift_keys != 2'b00) ? shifted_keys[code[6:0]] : plain_keys[code[6:0]];
        // letters go lower case unless exactly one of caps and shift is on
        if (ch >= CHR_UPPER_A && ch <= CHR_UPPER_Z &&
            (((led_state & LED_CAPS) != 3'd0) == (shift_keys != 2'b00)))
          ch = ch + CASE_OFFSET;
      end
      if (code == SC_BKSP) ch = CHR_BS;
      if (code == SC_ENTER) ch = CHR_LF;
      if (ch != 8'h00) begin
        tgts[n] = TGT_HOST;
        vals[n] = ch;
        n++;
      end
      case (code)
        SC_LSHIFT:     shift_keys[0] = 1'b1;
        SC_RSHIFT:     shift_keys[1] = 1'b1;
        SC_LSHIFT_REL: shift_keys[0] = 1'b0;
        SC_RSHIFT_REL: shift_keys[1] = 1'b0;
        SC_CAPS: begin
          led_state = led_state ^ LED_CAPS;
          queue_led_cmd();
        end
        SC_NUM: begin
          led_state = led_state ^ LED_NUM;
          queue_led_cmd();
        end
        SC_SCROLL: begin
          led_state = led_state ^ LED_SCROLL;
          queue_led_cmd();
        end
        ACK_BYTE: ack_pending = 1'b0;
        RESEND_BYTE: begin
          if (ack_pending) begin
            tgts[n] = TGT_KBD;
            vals[n] = sent_cmd;
            n++;
          end
        end
        default: ;
      endcase
    end
    // one command byte goes out whenever nothing is awaiting an ack
    if (led_cmd_fifo.size() != 0 && !ack_pending) begin
      sent_cmd    = led_cmd_fifo.pop_front();
      ack_pending = 1'b1;
      tgts[n]     = TGT_KBD;
      vals[n]     = sent_cmd;
      n++;
    end
    if (typed_active) begin
      if (typed_row.has_res) begin
        r.target = typed_row.tgt;
        r.value  = typed_row.val;
        r.leds   = typed_row.leds;
        r.last   = 1'b1;
        expected_beats.push_back(r);
      end
    end else begin
      for (int i = 0; i < n; i++) begin
        r.target = tgts[i];
        r.value  = vals[i];
        r.leds   = led_state;
        r.last   = (i == n - 1);
        expected_beats.push_back(r);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sender: bursts of random length, random gaps, drive on the falling edge
  // ---------------------------------------------------------------------------
  task automatic send_beat(input logic kind, input logic [7:0] code);
    int gap;
    if (burst_left == 0) begin
      gap = gaps_on ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= code;
    s_axis_tuser  <= kind;
    burst_left--;
    do @(posedge clk); while (!s_axis_tready);
    beats_sent++;
    decode_scancode(kind, code);
  endtask

  // stop sending and wait until every owed beat has come out
  task automatic wait_drained();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_start_leds(input logic [2:0] v);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    start_leds = v;
  endtask

  function automatic logic [7:0] pick_lock_key();
    case ($urandom_range(0, 2))
      0:       return SC_CAPS;
      1:       return SC_NUM;
      default: return SC_SCROLL;
    endcase
  endfunction

  // one random sequence: mostly well-formed typing and lock-key exchanges,
  // some queue floods, protocol noise and plain garbage bytes
  task automatic send_random_sequence();
    int         sel;
    logic       shifted;
    logic [7:0] shk;
    logic [7:0] key;
    sel = $urandom_range(0, 99);
    if (sel < 40) begin
      shifted = ($urandom_range(0, 2) == 0);
      shk     = $urandom_range(0, 1) ? SC_LSHIFT : SC_RSHIFT;
      if (shifted) send_beat(KIND_SCAN, shk);
      repeat ($urandom_range(1, 8)) begin
        key = 8'($urandom_range(0, 127));
        send_beat(KIND_SCAN, key);
        if ($urandom_range(0, 2) == 0) send_beat(KIND_SCAN, key | 8'h80);
      end
      if (shifted) send_beat(KIND_SCAN, (shk == SC_LSHIFT) ? SC_LSHIFT_REL : SC_RSHIFT_REL);
    end else if (sel < 58) begin
      // lock key, maybe a resend or two, then ack both command bytes
      send_beat(KIND_SCAN, pick_lock_key());
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 2)) send_beat(KIND_SCAN, RESEND_BYTE);
      if ($urandom_range(0, 3) == 0) send_beat(KIND_SCAN, 8'($urandom_range(0, 127)));
      send_beat(KIND_SCAN, ACK_BYTE);
      if ($urandom_range(0, 4) == 0) send_beat(KIND_SCAN, RESEND_BYTE);
      send_beat(KIND_SCAN, ACK_BYTE);
    end else if (sel < 64) begin
      send_beat(KIND_START, 8'($urandom_range(0, 255)));
      send_beat(KIND_SCAN, ACK_BYTE);
      send_beat(KIND_SCAN, ACK_BYTE);
    end else if (sel < 67) begin
      // flood: enough toggles without acks to overflow the command queue
      repeat ($urandom_range(17, 20)) send_beat(KIND_SCAN, pick_lock_key());
      repeat ($urandom_range(34, 40)) send_beat(KIND_SCAN, ACK_BYTE);
    end else if (sel < 80) begin
      repeat ($urandom_range(1, 4)) begin
        case ($urandom_range(0, 3))
          0:       send_beat(KIND_SCAN, ACK_BYTE);
          1:       send_beat(KIND_SCAN, RESEND_BYTE);
          2:       send_beat(KIND_SCAN, SC_LSHIFT_REL);
          default: send_beat(KIND_SCAN, SC_RSHIFT_REL);
        endcase
      end
    end else begin
      send_beat(($urandom_range(0, 9) == 0) ? KIND_START : KIND_SCAN,
                8'($urandom_range(0, 255)));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Clock, cycle limit
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: stall pattern drawn at random from four modes; one long hold-off on
  // request, during which the sender keeps pushing and the block backs up
  // ---------------------------------------------------------------------------
  initial begin
    int   cyc;
    int   mode;
    logic rdy;
    cyc  = 0;
    mode = 0;
    wait (!rst);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      if (cyc % 64 == 0) mode = $urandom_range(0, 3);
      cyc++;
      case (mode)
        0:       rdy = 1'b1;
        1:       rdy = 1'($urandom_range(0, 1));
        2:       rdy = (cyc % 4 == 0);
        default: rdy = ($urandom_range(0, 6) != 0);
      endcase
      m_axis_tready <= rdy;
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker: each beat against the oldest owed beat
  // ---------------------------------------------------------------------------
  function automatic void report(input string field, input int exp_v, input int act_v);
    errors++;
    if (errors <= MAX_REPORTS)
      $error("%s mismatch: expected %0h, got %0h", field, exp_v, act_v);
  endfunction

  always @(posedge clk) begin
    result_t exp_beat;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_beats.size() == 0) begin
        report("unexpected beat, byte_value", 0, int'(m_axis_tdata[7:0]));
      end else begin
        exp_beat = expected_beats.pop_front();
        if (m_axis_tuser !== exp_beat.target)
          report("target", int'(exp_beat.target), int'(m_axis_tuser));
        if (m_axis_tdata[7:0] !== exp_beat.value)
          report("byte_value", int'(exp_beat.value), int'(m_axis_tdata[7:0]));
        if (m_axis_tdata[10:8] !== exp_beat.leds)
          report("led_bits", int'(exp_beat.leds), int'(m_axis_tdata[10:8]));
        if (m_axis_tlast !== exp_beat.last)
          report("last", int'(exp_beat.last), int'(m_axis_tlast));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int quota;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed part, all LEDs loaded for the start row at the end
    write_start_leds(3'd7);
    for (int i = 0; i < NUM_ROWS; i++) begin
      typed_row    = directed_rows[i];
      typed_active = directed_rows[i].typed;
      send_beat(directed_rows[i].kind, directed_rows[i].scan);
    end
    typed_active = 1'b0;
    wait_drained();

    // random phases, a new LED setting each, block idle at every write
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       write_start_leds(3'd0);
        1:       write_start_leds(3'd7);
        default: write_start_leds(3'($urandom_range(0, 7)));
      endcase
      gaps_on = (p != 3);             // one phase with back-to-back beats
      if (p == 2) hold_req = 1'b1;    // long receiver hold-off under load
      quota = beats_sent + RANDOM_ITEMS / PHASES;
      send_beat(KIND_START, 8'($urandom_range(0, 255)));
      while (beats_sent < quota) send_random_sequence();
      wait_drained();
    end

    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire
